FILE: rtl/xed_pkg.sv
package xed_pkg;

	localparam int NumEnt  = 5;
	localparam int HoldMax = 5;
	localparam int CandLen = HoldMax + 1;

	localparam logic [7:0] AMP = 8'h26;

	// Entity spellings, padded with zero beyond their length.
	localparam logic [7:0] ENT_TEXT [NumEnt][CandLen] = '{
		'{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},
		'{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},
		'{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},
		'{8'h26, 8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},
		'{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00}
	};
	localparam logic [2:0] ENT_LEN [NumEnt] = '{3'd4, 3'd4, 3'd6, 3'd6, 3'd5};
	localparam logic [7:0] ENT_CHAR [NumEnt] = '{8'h3c, 8'h3e, 8'h22, 8'h27, 8'h26};

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_pay_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_end;
	} out_pay_t;

	// One queued run of results caused by a single input byte.
	typedef struct packed {
		logic [CandLen-1:0][7:0] bytes;
		logic [2:0]              cnt;
		logic                    last;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

FILE: rtl/xed_stream_if.sv
interface xed_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/xed_front.sv
module xed_front (
	input  logic              clk,
	input  logic              arst_n,
	xed_stream_if.sink        din,
	input  xed_pkg::q_stat_t  q_stat,
	output logic              push,
	output xed_pkg::cmd_t     push_cmd
);

	logic [2:0] pend_cnt_q;
	logic [7:0] pend_q [xed_pkg::HoldMax];

	logic [2:0] cnt_eff;
	logic [2:0] len;
	logic [7:0] cand [xed_pkg::CandLen];
	logic       full_hit;
	logic       pre_hit;
	logic [7:0] full_char;
	logic       accept;

	assign din.ready = !q_stat.full;
	assign accept    = din.valid && din.ready;

	always_comb begin
		logic eq;
		cnt_eff = (pend_cnt_q > 3'(xed_pkg::HoldMax)) ? 3'(xed_pkg::HoldMax) : pend_cnt_q;
		len     = cnt_eff + 3'd1;
		for (int i = 0; i < xed_pkg::HoldMax; i++) begin
			cand[i] = (i < cnt_eff) ? pend_q[i] : din.data.in_byte;
		end
		cand[xed_pkg::HoldMax] = din.data.in_byte;

		full_hit  = 1'b0;
		pre_hit   = 1'b0;
		full_char = '0;
		for (int e = 0; e < xed_pkg::NumEnt; e++) begin
			eq = 1'b1;
			for (int k = 0; k < xed_pkg::CandLen; k++) begin
				if (k < len && xed_pkg::ENT_TEXT[e][k] != cand[k]) begin
					eq = 1'b0;
				end
			end
			if (eq && xed_pkg::ENT_LEN[e] == len) begin
				full_hit  = 1'b1;
				full_char = xed_pkg::ENT_CHAR[e];
			end
			if (eq && xed_pkg::ENT_LEN[e] > len) begin
				pre_hit = 1'b1;
			end
		end

		for (int i = 0; i < xed_pkg::CandLen; i++) begin
			push_cmd.bytes[i] = cand[i];
		end
		push_cmd.last = din.data.in_last;
		if (full_hit) begin
			push_cmd.bytes[0] = full_char;
			push_cmd.cnt      = 3'd1;
		end else if (pre_hit) begin
			push_cmd.cnt = din.data.in_last ? len : 3'd0;
		end else if (din.data.in_byte == xed_pkg::AMP) begin
			push_cmd.cnt = din.data.in_last ? len : cnt_eff;
		end else begin
			push_cmd.cnt = len;
		end
		push = accept && (push_cmd.cnt != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q <= '0;
		end else if (accept) begin
			if (din.data.in_last || full_hit) begin
				pend_cnt_q <= '0;
			end else if (pre_hit) begin
				pend_cnt_q <= len;
			end else if (din.data.in_byte == xed_pkg::AMP) begin
				pend_cnt_q <= 3'd1;
			end else begin
				pend_cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !full_hit) begin
			if (pre_hit) begin
				pend_q[cnt_eff] <= din.data.in_byte;
			end else begin
				pend_q[0] <= din.data.in_byte;
			end
		end
	end

endmodule

FILE: rtl/xed_queue.sv
module xed_queue #(
	parameter int Depth = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  xed_pkg::cmd_t     push_cmd,
	input  logic              pop,
	output xed_pkg::cmd_t     head,
	output xed_pkg::q_stat_t  q_stat
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	xed_pkg::cmd_t   mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] fill_q;

	assign q_stat.full  = (fill_q == CntW'(Depth));
	assign q_stat.empty = (fill_q == '0);
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

FILE: rtl/xed_back.sv
module xed_back (
	input  logic              clk,
	input  logic              arst_n,
	input  xed_pkg::cmd_t     head,
	input  xed_pkg::q_stat_t  q_stat,
	output logic              pop,
	xed_stream_if.source      dout
);

	logic [2:0]        idx_q;
	logic              valid_q;
	xed_pkg::out_pay_t out_q;
	logic              load;
	logic              is_end;

	assign load       = !q_stat.empty && (!valid_q || dout.ready);
	assign is_end     = (idx_q == head.cnt - 3'd1);
	assign pop        = load && is_end;
	assign dout.valid = valid_q;
	assign dout.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_end ? 3'd0 : idx_q + 3'd1;
			end else if (dout.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte   <= head.bytes[idx_q];
			out_q.run_last   <= is_end;
			out_q.string_end <= is_end && head.last;
		end
	end

endmodule

FILE: rtl/xml_entity_decoder_unit.sv
// Channel | Direction | Payload                          | Handshake
// din     | in        | in_byte, in_last                 | valid/ready
// dout    | out       | out_byte, run_last, string_end   | valid/ready
//
// An input byte is taken in every cycle while the command queue has room;
// its decoding, including entity matching, is settled in that same cycle.
// The results of one byte (up to six) leave one per cycle from the output
// register while dout is ready, so a byte that yields n results takes n transfers.
// Reset (arst_n low) empties the queue and drops any held entity prefix.
// The queue fills on a stall on dout, or when runs of several results outpace
// the input, and only then is din held off.
module xml_entity_decoder_unit #(
	parameter int QueueDepth = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	xed_stream_if.sink   din,
	xed_stream_if.source dout
);

	// The front end matches the held prefix plus the new byte against the
	// five entities and turns the outcome into a run of result bytes.
	xed_pkg::cmd_t    push_cmd;
	xed_pkg::cmd_t    head;
	xed_pkg::q_stat_t q_stat;
	logic             push;
	logic             pop;

	xed_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.din      (din),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// The queue lets the front end carry on while earlier runs drain.
	xed_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	// The back end walks through each run one byte per transfer.
	xed_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.dout   (dout)
	);

	// The final byte of a string always closes the run of its input byte.
	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && dout.data.string_end |-> dout.data.run_last)
		else $error("string_end without run_last");

	// The queue fill level can never be both at capacity and at zero.
	a_queue_status: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty together");

	// An empty queue must never hold off the input side.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.empty |-> din.ready)
		else $error("input stalled with an empty queue");

	// Nothing is taken from the queue when it holds nothing.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from an empty queue");

endmodule
